[src/rvpc_pkg.sv]
// Shared types and constants for the resampled voxel presence compare unit.
// Used by the channel interfaces and by the top level; depends on nothing.
package rvpc_pkg;

    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 64;
    localparam int VoxelW    = 32;
    localparam int ClassW    = 3;
    localparam int OffsetW   = 30;
    localparam int AccumW    = 44;
    localparam int SizeFieldW = 10;

    localparam logic [CfgIndexW-1:0] REG_GRID_SIZES = 3'd0;
    localparam logic [CfgIndexW-1:0] REG_AXIS_FIRST = 3'd1;
    localparam logic [CfgIndexW-1:0] REG_AXIS_LAST  = 3'd6;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    localparam logic [ClassW-1:0] CLASS_BACKGROUND = 3'd0;
    localparam logic [ClassW-1:0] CLASS_FIRST_ONLY = 3'd1;
    localparam logic [ClassW-1:0] CLASS_SECOND_ONLY = 3'd2;
    localparam logic [ClassW-1:0] CLASS_SAME       = 3'd3;
    localparam logic [ClassW-1:0] CLASS_DIFFERENT  = 3'd4;

    // Single precision 1.0, the point at and above which the tolerance is relative.
    localparam logic [VoxelW-1:0] FLOAT_ONE = 32'h3F80_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_ADDR,
        ST_JUDGE,
        ST_DECIDE
    } state_t;

endpackage

[src/rvpc_in_if.sv]
// Input channel of the compare unit: command and voxel bit pattern.
// Depends on rvpc_pkg for field widths.
interface rvpc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [rvpc_pkg::VoxelW-1:0]   voxel_bits;

    modport source (output valid, output cmd, output voxel_bits, input ready);
    modport sink   (input valid, input cmd, input voxel_bits, output ready);
endinterface

[src/rvpc_out_if.sv]
// Result channel of the compare unit: class code, raster offset, last flag.
// Depends on rvpc_pkg for field widths.
interface rvpc_out_if;
    logic                          valid;
    logic                          ready;
    logic [rvpc_pkg::ClassW-1:0]   class_code;
    logic [rvpc_pkg::OffsetW-1:0]  voxel_offset;
    logic                          last_voxel;

    modport source (output valid, output class_code, output voxel_offset,
                    output last_voxel, input ready);
    modport sink   (input valid, input class_code, input voxel_offset,
                    input last_voxel, output ready);
endinterface

[src/rvpc_cfg_if.sv]
// Configuration write channel: register index and write data.
// Depends on rvpc_pkg for field widths.
interface rvpc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rvpc_pkg::CfgIndexW-1:0]  index;
    logic [rvpc_pkg::CfgDataW-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/resampled_voxel_presence_compare_unit.sv]
// Top level: second-volume memory, affine walk, nearest neighbor lookup and classifier.
// Depends on rvpc_pkg and the interfaces rvpc_in_if, rvpc_out_if, rvpc_cfg_if.
//
//   channel | dir | beat contents                      | accepted when
//   vin     | in  | cmd, voxel_bits                    | vin.valid && vin.ready
//   res     | out | class_code, voxel_offset, last_voxel | res.valid && res.ready
//   cfg     | in  | index, data                        | cfg.valid && cfg.ready
//
// A load beat is written to the memory at acceptance.
// A classify beat runs through map, address and read, judge, decide;
// the single memory read port and the two multiplies of the address chain set them.
// The result waits in an output register, so the next beat is taken meanwhile;
// the decide step stalls only if the previous result is still unread.
// Reset clears control state and configuration registers; memory and datapath are not cleared.
module resampled_voxel_presence_compare_unit #(
    parameter int SECOND_VOXELS = 32768,
    parameter int AXIS_BITS     = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    rvpc_in_if.sink          vin,
    rvpc_out_if.source       res,
    rvpc_cfg_if.sink         cfg
);

    localparam int AddrW  = $clog2(SECOND_VOXELS);
    localparam int AB     = AXIS_BITS;
    localparam int P1W    = 2 * AB + 1;
    localparam int TW     = 2 * AB + 2;
    localparam int SoffW  = (3 * AB + 3 > AddrW + 1) ? 3 * AB + 3 : AddrW + 1;
    localparam int AccW   = rvpc_pkg::AccumW;
    localparam int DmW    = 61;
    localparam int XW     = 60;
    localparam int ProdW  = 76;

    // Configuration registers.
    logic [59:0] grid_reg;
    logic [63:0] axis_reg [6];

    // Control.
    rvpc_pkg::state_t state_reg, state_next;
    logic [AddrW-1:0] load_pos_reg;
    logic [AB-1:0]    wx_reg, wy_reg, wz_reg;
    logic [AccW-1:0]  point_reg [3];
    logic [AccW-1:0]  row_reg   [3];
    logic [AccW-1:0]  plane_reg [3];
    logic             out_valid_reg;

    // Datapath registers.
    logic [31:0]      bits_reg;
    logic [AB-1:0]    idx_reg [3];
    logic             inside_reg;
    logic [P1W-1:0]   p1_reg;
    logic [P1W-1:0]   pw_reg;
    logic [AB-1:0]    ox_reg, oy_reg;
    logic             last_reg;
    logic             hit_reg;
    logic [SoffW-1:0] off_reg;
    logic [31:0]      rd_reg;
    logic [31:0]      mem [SECOND_VOXELS];
    logic [2:0]       pre_code_reg;
    logic             need_cmp_reg, big_mode_reg, zero_lim_reg, force_same_reg;
    logic [6:0]       m_reg;
    logic [DmW-1:0]   dm_reg;
    logic [XW-1:0]    x_reg;
    logic [2:0]       code_reg;
    logic [29:0]      voff_reg;
    logic             vlast_reg;

    logic vin_fire, out_free, decide_go;

    assign vin.ready  = (state_reg == rvpc_pkg::ST_IDLE);
    assign vin_fire   = vin.valid && vin.ready;
    assign cfg.ready  = 1'b1;
    assign out_free   = !out_valid_reg || res.ready;
    assign decide_go  = (state_reg == rvpc_pkg::ST_DECIDE) && out_free;

    assign res.valid        = out_valid_reg;
    assign res.class_code   = code_reg;
    assign res.voxel_offset = voff_reg;
    assign res.last_voxel   = vlast_reg;

    // Grid sizes minus one.
    logic [AB-1:0] fs [3];
    logic [AB-1:0] ss [3];
    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            fs[n] = grid_reg[10 * n +: AB];
            ss[n] = grid_reg[10 * (n + 3) +: AB];
        end
    end

    // Coefficients sign-extended to accumulator width.
    logic [AccW-1:0] base_c [3];
    logic [AccW-1:0] xs_c   [3];
    logic [AccW-1:0] ys_c   [3];
    logic [AccW-1:0] zs_c   [3];
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            base_c[a] = AccW'($signed(axis_reg[2 * a][31:0]));
            xs_c[a]   = AccW'($signed(axis_reg[2 * a][63:32]));
            ys_c[a]   = AccW'($signed(axis_reg[2 * a + 1][31:0]));
            zs_c[a]   = AccW'($signed(axis_reg[2 * a + 1][63:32]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                axis_reg[i] <= '0;
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == rvpc_pkg::REG_GRID_SIZES)
            begin
                grid_reg <= cfg.data[59:0];
            end
            else if (cfg.index >= rvpc_pkg::REG_AXIS_FIRST &&
                     cfg.index <= rvpc_pkg::REG_AXIS_LAST)
            begin
                axis_reg[3'(cfg.index - rvpc_pkg::REG_AXIS_FIRST)] <= cfg.data;
            end
        end
    end

    // Map step: current accumulators, rounding, bounds.
    logic            walk_start;
    logic [AccW-1:0] pt_cur [3];
    logic [AccW-1:0] row_cur [3];
    logic [AccW-1:0] pl_cur [3];
    logic [AB-1:0]   idx_c [3];
    logic            inside_c;
    always_comb
    begin
        logic [AccW-1:0] mag;
        logic [AccW-1:0] sum;
        logic [23:0]     r;
        logic            neg;
        walk_start = (wx_reg == '0) && (wy_reg == '0) && (wz_reg == '0);
        inside_c   = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            pt_cur[a]  = walk_start ? base_c[a] : point_reg[a];
            row_cur[a] = walk_start ? base_c[a] : row_reg[a];
            pl_cur[a]  = walk_start ? base_c[a] : plane_reg[a];
            neg = pt_cur[a][AccW-1];
            mag = neg ? (~pt_cur[a] + AccW'(1)) : pt_cur[a];
            sum = mag + AccW'(1 << 19);
            r   = sum[AccW-1:20];
            if (neg && r != '0)
            begin
                inside_c = 1'b0;
            end
            if (r > 24'(ss[a]))
            begin
                inside_c = 1'b0;
            end
            idx_c[a] = neg ? '0 : r[AB-1:0];
        end
    end

    // Address step.
    logic [TW-1:0]    t_c, tw_c;
    logic [SoffW-1:0] soff_c, off_c;
    always_comb
    begin
        t_c    = TW'(idx_reg[1]) + TW'(p1_reg);
        soff_c = SoffW'(idx_reg[0]) + SoffW'(ss[0]) * SoffW'(t_c) + SoffW'(t_c);
        tw_c   = TW'(oy_reg) + TW'(pw_reg);
        off_c  = SoffW'(ox_reg) + SoffW'(fs[0]) * SoffW'(tw_c) + SoffW'(tw_c);
    end

    // Judge step: presence, alignment and difference of the two values.
    logic [31:0] av, bv, ua, ub, big, sml;
    logic        pa, pb;
    logic [23:0] ma, mb;
    logic signed [9:0] ea, eb, kk, nn, mm;
    logic [XW-1:0]  x_c;
    logic [DmW-1:0] dm_c;
    logic [2:0]     pre_code_c;
    logic           need_cmp_c;
    always_comb
    begin
        av  = bits_reg;
        bv  = hit_reg ? rd_reg : '0;
        pa  = (av[30:23] != 8'hFF) && (av[30:0] != '0);
        pb  = (bv[30:23] != 8'hFF) && (bv[30:0] != '0);
        ua  = {1'b0, av[30:0]};
        ub  = {1'b0, bv[30:0]};
        big = (ua >= ub) ? ua : ub;
        sml = (ua >= ub) ? ub : ua;
        ma  = (big[30:23] == '0) ? {1'b0, big[22:0]} : {1'b1, big[22:0]};
        ea  = (big[30:23] == '0) ? -10'sd149 : $signed({2'b0, big[30:23]}) - 10'sd150;
        mb  = (sml[30:23] == '0) ? {1'b0, sml[22:0]} : {1'b1, sml[22:0]};
        eb  = (sml[30:23] == '0) ? -10'sd149 : $signed({2'b0, sml[30:23]}) - 10'sd150;
        kk  = ea - eb;
        if (kk > 10'sd36)
        begin
            mb = '0;
            kk = '0;
            eb = ea;
        end
        x_c  = XW'(ma) << kk[5:0];
        dm_c = (av[31] ^ bv[31]) ? (DmW'(x_c) + DmW'(mb)) : (DmW'(x_c) - DmW'(mb));
        nn   = -eb;
        mm   = nn - 10'sd4;
        need_cmp_c = 1'b0;
        if (pa && !pb)
        begin
            pre_code_c = rvpc_pkg::CLASS_FIRST_ONLY;
        end
        else if (!pa && pb)
        begin
            pre_code_c = rvpc_pkg::CLASS_SECOND_ONLY;
        end
        else if (!pa)
        begin
            pre_code_c = rvpc_pkg::CLASS_BACKGROUND;
        end
        else
        begin
            pre_code_c = rvpc_pkg::CLASS_SAME;
            need_cmp_c = 1'b1;
        end
    end

    // Decide step: the tolerance tests as exact integer compares.
    logic [ProdW-1:0] dm_w, p10k, p625, lim_w;
    logic [2:0]       code_c;
    logic             same_c;
    always_comb
    begin
        dm_w  = ProdW'(dm_reg);
        p10k  = (dm_w << 13) + (dm_w << 10) + (dm_w << 9) + (dm_w << 8) + (dm_w << 4);
        p625  = (dm_w << 9) + (dm_w << 6) + (dm_w << 5) + (dm_w << 4) + dm_w;
        lim_w = ProdW'(1) << m_reg;
        if (big_mode_reg)
        begin
            same_c = p10k <= ProdW'(x_reg);
        end
        else if (zero_lim_reg)
        begin
            same_c = (dm_reg == '0);
        end
        else if (force_same_reg)
        begin
            same_c = 1'b1;
        end
        else
        begin
            same_c = p625 <= lim_w;
        end
        if (need_cmp_reg)
        begin
            code_c = same_c ? rvpc_pkg::CLASS_SAME : rvpc_pkg::CLASS_DIFFERENT;
        end
        else
        begin
            code_c = pre_code_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rvpc_pkg::ST_IDLE:
            begin
                if (vin_fire && vin.cmd == rvpc_pkg::CMD_CLASSIFY)
                begin
                    state_next = rvpc_pkg::ST_MAP;
                end
            end
            rvpc_pkg::ST_MAP:    state_next = rvpc_pkg::ST_ADDR;
            rvpc_pkg::ST_ADDR:   state_next = rvpc_pkg::ST_JUDGE;
            rvpc_pkg::ST_JUDGE:  state_next = rvpc_pkg::ST_DECIDE;
            rvpc_pkg::ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = rvpc_pkg::ST_IDLE;
                end
            end
            default: state_next = rvpc_pkg::ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rvpc_pkg::ST_IDLE;
            load_pos_reg  <= '0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            wz_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                point_reg[a] <= '0;
                row_reg[a]   <= '0;
                plane_reg[a] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (vin_fire && vin.cmd == rvpc_pkg::CMD_LOAD)
            begin
                if (load_pos_reg == AddrW'(SECOND_VOXELS - 1))
                begin
                    load_pos_reg <= '0;
                end
                else
                begin
                    load_pos_reg <= load_pos_reg + AddrW'(1);
                end
            end
            if (state_reg == rvpc_pkg::ST_MAP)
            begin
                if (wx_reg < fs[0])
                begin
                    wx_reg <= wx_reg + AB'(1);
                    for (int a = 0; a < 3; a++)
                    begin
                        point_reg[a] <= pt_cur[a] + xs_c[a];
                        row_reg[a]   <= row_cur[a];
                        plane_reg[a] <= pl_cur[a];
                    end
                end
                else if (wy_reg < fs[1])
                begin
                    wx_reg <= '0;
                    wy_reg <= wy_reg + AB'(1);
                    for (int a = 0; a < 3; a++)
                    begin
                        row_reg[a]   <= row_cur[a] + ys_c[a];
                        point_reg[a] <= row_cur[a] + ys_c[a];
                        plane_reg[a] <= pl_cur[a];
                    end
                end
                else if (wz_reg < fs[2])
                begin
                    wx_reg <= '0;
                    wy_reg <= '0;
                    wz_reg <= wz_reg + AB'(1);
                    for (int a = 0; a < 3; a++)
                    begin
                        plane_reg[a] <= pl_cur[a] + zs_c[a];
                        row_reg[a]   <= pl_cur[a] + zs_c[a];
                        point_reg[a] <= pl_cur[a] + zs_c[a];
                    end
                end
                else
                begin
                    wx_reg       <= '0;
                    wy_reg       <= '0;
                    wz_reg       <= '0;
                    load_pos_reg <= '0;
                end
            end
            if (decide_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Second-volume memory.
    always_ff @(posedge clk)
    begin
        if (vin_fire && vin.cmd == rvpc_pkg::CMD_LOAD)
        begin
            mem[load_pos_reg] <= vin.voxel_bits;
        end
        if (state_reg == rvpc_pkg::ST_ADDR)
        begin
            rd_reg <= mem[soff_c[AddrW-1:0]];
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (vin_fire)
        begin
            bits_reg <= vin.voxel_bits;
        end
        if (state_reg == rvpc_pkg::ST_MAP)
        begin
            for (int a = 0; a < 3; a++)
            begin
                idx_reg[a] <= idx_c[a];
            end
            inside_reg <= inside_c;
            p1_reg     <= P1W'(ss[1]) * P1W'(idx_c[2]) + P1W'(idx_c[2]);
            pw_reg     <= P1W'(fs[1]) * P1W'(wz_reg) + P1W'(wz_reg);
            ox_reg     <= wx_reg;
            oy_reg     <= wy_reg;
            last_reg   <= (wx_reg >= fs[0]) && (wy_reg >= fs[1]) && (wz_reg >= fs[2]);
        end
        if (state_reg == rvpc_pkg::ST_ADDR)
        begin
            hit_reg <= inside_reg && (soff_c < SoffW'(SECOND_VOXELS));
            off_reg <= off_c;
        end
        if (state_reg == rvpc_pkg::ST_JUDGE)
        begin
            pre_code_reg   <= pre_code_c;
            need_cmp_reg   <= need_cmp_c;
            big_mode_reg   <= big >= rvpc_pkg::FLOAT_ONE;
            zero_lim_reg   <= nn < 10'sd4;
            force_same_reg <= mm > 10'sd71;
            m_reg          <= mm[6:0];
            dm_reg         <= dm_c;
            x_reg          <= x_c;
        end
        if (decide_go)
        begin
            code_reg  <= code_c;
            voff_reg  <= 30'(off_reg);
            vlast_reg <= last_reg;
        end
    end

endmodule
